>>> rtl/dspq_pkg.sv
// shared constants, types and sequencer codes for the dual stepper pulse queue
`timescale 1ns / 1ps

package dspq_pkg;

  // command pool size and the width of a pool slot pointer
  localparam int POOL_DEPTH = 256;
  localparam int PTR_W      = $clog2(POOL_DEPTH);

  // field widths
  localparam int IVL_W  = 16;
  localparam int PINS_W = 2;
  localparam int CNT_W  = 16;

  // allocation starts at slot one after reset
  localparam int ALLOC_RESET = 1;

  // bit positions inside a stored pin pair
  localparam int PIN_DIR  = 0;
  localparam int PIN_STEP = 1;

  typedef logic [PTR_W-1:0] ptr_t;

  // input item kinds
  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // motor index values
  localparam logic MOTOR_FIRST  = 1'b0;
  localparam logic MOTOR_SECOND = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_WRITE,
    S_ENQ_LINK,
    S_TICK,
    S_CHECK,
    S_PHASE,
    S_NEXT_ADD,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic enq_write;
    logic enq_link;
    logic tick_inc;
    logic motor_read;
    logic phase;
    logic next_add;
    logic next_motor;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic motor;
    logic match;
    logic ivl_nonzero;
    logic head_is_tail;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/dspq_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dspq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dspq_datapath.sv
// datapath: pool memories, list pointers, compare values, pins and output register
`timescale 1ns / 1ps

module dspq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dspq_pkg::dp_cmd_t             cmd,
  output dspq_pkg::dp_status_t          status,
  input  logic                          motor_select,
  input  logic                          direction,
  input  logic                          step_enable,
  input  logic [dspq_pkg::IVL_W-1:0]    interval,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          first_step,
  output logic                          first_dir,
  output logic                          second_step,
  output logic                          second_dir,
  output logic                          first_busy,
  output logic                          second_busy,
  output logic                          ready_res
);
  import dspq_pkg::*;

  // captured item
  logic              item_sel;
  logic [PINS_W-1:0] item_pins;
  logic [IVL_W-1:0]  item_ivl;

  // control state
  ptr_t              alloc;
  ptr_t              head [2];
  ptr_t              tail [2];
  logic [1:0]        active;
  logic [CNT_W-1:0]  compare [2];
  logic [CNT_W-1:0]  tick;
  logic [1:0]        step;
  logic [1:0]        dir;
  logic              motor;
  logic              chain;

  // pool read data
  logic [IVL_W-1:0]  ivl_q;
  logic [PINS_W-1:0] pins_q;
  ptr_t              link_q;

  // pool write and read ports
  logic              ivl_we;
  ptr_t              ivl_waddr;
  logic [IVL_W-1:0]  ivl_wdata;
  ptr_t              ivl_raddr;
  logic              link_we;
  ptr_t              link_waddr;
  ptr_t              link_wdata;
  ptr_t              alloc_inc;
  logic              ivl_nonzero;

  assign ivl_nonzero = (ivl_q != '0);

  // wrapping slot allocation
  always_comb begin
    if (alloc == ptr_t'(POOL_DEPTH - 1)) begin
      alloc_inc = '0;
    end else begin
      alloc_inc = alloc + ptr_t'(1);
    end
  end

  // pool port selection
  always_comb begin
    ivl_we     = cmd.enq_write | (cmd.phase & ivl_nonzero);
    ivl_waddr  = cmd.enq_write ? alloc : head[motor];
    ivl_wdata  = cmd.enq_write ? item_ivl : '0;
    ivl_raddr  = cmd.motor_read ? head[motor] : link_q;
    link_we    = cmd.enq_write | (cmd.enq_link & chain);
    link_waddr = cmd.enq_write ? alloc : tail[item_sel];
    link_wdata = cmd.enq_write ? '0 : alloc;
  end

  dspq_ram #(.WIDTH(IVL_W), .DEPTH(POOL_DEPTH)) u_ivl_ram (
    .clk   (clk),
    .we    (ivl_we),
    .waddr (ivl_waddr),
    .wdata (ivl_wdata),
    .raddr (ivl_raddr),
    .rdata (ivl_q)
  );

  dspq_ram #(.WIDTH(PINS_W), .DEPTH(POOL_DEPTH)) u_pins_ram (
    .clk   (clk),
    .we    (cmd.enq_write),
    .waddr (alloc),
    .wdata (item_pins),
    .raddr (head[motor]),
    .rdata (pins_q)
  );

  dspq_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head[motor]),
    .rdata (link_q)
  );

  // item capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_sel  <= motor_select;
      item_pins <= {step_enable, direction};
      item_ivl  <= interval;
    end
  end

  // list, timer and pin state
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc      <= ptr_t'(ALLOC_RESET);
      head[0]    <= '0;
      head[1]    <= '0;
      tail[0]    <= '0;
      tail[1]    <= '0;
      active     <= '0;
      compare[0] <= '0;
      compare[1] <= '0;
      tick       <= '0;
      step       <= '0;
      dir        <= '0;
      motor      <= MOTOR_FIRST;
      chain      <= 1'b0;
    end else begin
      // enqueue: start an idle motor, remember whether the tail needs a link
      if (cmd.enq_write) begin
        chain <= active[item_sel];
        if (!active[item_sel]) begin
          head[item_sel]    <= alloc;
          active[item_sel]  <= 1'b1;
          compare[item_sel] <= tick + item_ivl;
        end
      end
      if (cmd.enq_link) begin
        tail[item_sel] <= alloc;
        alloc          <= alloc_inc;
      end
      // tick: advance counter and restart the motor scan
      if (cmd.tick_inc) begin
        tick  <= tick + CNT_W'(1);
        motor <= MOTOR_FIRST;
      end
      if (cmd.next_motor) begin
        motor <= MOTOR_SECOND;
      end
      // one phase of the head command
      if (cmd.phase) begin
        if (ivl_nonzero) begin
          step[motor]    <= 1'b0;
          dir[motor]     <= pins_q[PIN_DIR];
          compare[motor] <= compare[motor] + ivl_q;
        end else begin
          step[motor] <= step[motor] | pins_q[PIN_STEP];
          if (head[motor] != tail[motor]) begin
            head[motor] <= link_q;
          end else begin
            active[motor] <= 1'b0;
          end
        end
      end
      // next command's interval
      if (cmd.next_add) begin
        compare[motor] <= compare[motor] + ivl_q;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      first_step  <= step[0];
      first_dir   <= dir[0];
      second_step <= step[1];
      second_dir  <= dir[1];
      first_busy  <= active[0];
      second_busy <= active[1];
      ready_res   <= (alloc != head[0]) || (alloc != head[1]);
    end
  end

  // status to the controller
  always_comb begin
    status.motor        = motor;
    status.match        = active[motor] && (compare[motor] == tick);
    status.ivl_nonzero  = ivl_nonzero;
    status.head_is_tail = (head[motor] == tail[motor]);
    status.out_free     = !out_valid || out_ready;
  end

endmodule

>>> rtl/dspq_ctrl.sv
// controller: sequences enqueue writes and per-motor tick phases
`timescale 1ns / 1ps

module dspq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  dspq_pkg::dp_status_t status,
  output dspq_pkg::dp_cmd_t    cmd
);
  import dspq_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (mode == MODE_TICK) ? S_TICK : S_ENQ_WRITE;
        end
      end
      S_ENQ_WRITE: begin
        cmd.enq_write = 1'b1;
        state_next    = S_ENQ_LINK;
      end
      S_ENQ_LINK: begin
        cmd.enq_link = 1'b1;
        state_next   = S_FINISH;
      end
      S_TICK: begin
        cmd.tick_inc = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        // read the head entry of a matching motor, else move on
        if (status.match) begin
          cmd.motor_read = 1'b1;
          state_next     = S_PHASE;
        end else if (status.motor == MOTOR_FIRST) begin
          cmd.next_motor = 1'b1;
          state_next     = S_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_PHASE: begin
        cmd.phase = 1'b1;
        if (!status.ivl_nonzero && !status.head_is_tail) begin
          state_next = S_NEXT_ADD;
        end else if (status.motor == MOTOR_FIRST) begin
          cmd.next_motor = 1'b1;
          state_next     = S_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_NEXT_ADD: begin
        cmd.next_add = 1'b1;
        if (status.motor == MOTOR_FIRST) begin
          cmd.next_motor = 1'b1;
          state_next     = S_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/dual_stepper_command_pulse_queue.sv
// top level: two-motor step/direction pulse generator with shared command pool
// an enqueue runs capture, slot write, tail link and finish; a tick runs the counter step,
// then the controller's per-motor scan over the pool rams, then finish
// one item at a time: a new input is taken the cycle after its result loads, even
// while that result waits; a result loads only once the output register is free
// synchronous reset: allocation slot one, lists empty, motors idle, pins low; pool not cleared
`timescale 1ns / 1ps

module dual_stepper_command_pulse_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic                       motor_select,
  input  logic                       direction,
  input  logic                       step_enable,
  input  logic [dspq_pkg::IVL_W-1:0] interval,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       first_step,
  output logic                       first_dir,
  output logic                       second_step,
  output logic                       second_dir,
  output logic                       first_busy,
  output logic                       second_busy,
  output logic                       ready_res
);
  import dspq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  dspq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd)
  );

  // pool and motor state
  dspq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .motor_select (motor_select),
    .direction    (direction),
    .step_enable  (step_enable),
    .interval     (interval),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .first_step   (first_step),
    .first_dir    (first_dir),
    .second_step  (second_step),
    .second_dir   (second_dir),
    .first_busy   (first_busy),
    .second_busy  (second_busy),
    .ready_res    (ready_res)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: no transfer in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a phase only ever uses data read for a matching motor the cycle before
  a_phase_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.phase |-> $past(cmd.motor_read))
    else $error("phase without head read");

  // slot write is always followed by the tail link step
  a_enq_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_write |=> cmd.enq_link)
    else $error("enqueue link step skipped");
`endif

endmodule
